// ----- hdl/dmgn_pkg.sv -----
package dmgn_pkg;

    localparam int DEF_MAP_WIDTH  = 256;
    localparam int DEF_MAP_HEIGHT = 256;
    localparam int DEF_DEPTH_BITS = 16;
    localparam int DEF_GREY_SHIFT = 8;

    localparam int REQ_W    = 2;
    localparam int COORD_W  = 8;
    localparam int DEPTH_W  = 16;
    localparam int GREY_W   = 8;
    localparam int COUNT_W  = 17;
    localparam int STATUS_W = 2;
    localparam int MARGIN_W = 7;
    localparam int SPAN_W   = 17;
    localparam int SHIFT_W  = 5;
    localparam int AVAIL_W  = 9;
    localparam int PROD_W   = DEPTH_W + AVAIL_W;
    localparam int COMP_LSB = 8;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 7'd8;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    localparam int QUEUE_DEPTH = 2;

    localparam int NUM_CLASSES    = 17;
    localparam int NARROW_CLASSES = 8;

    localparam logic [SPAN_W-1:0] LAD_LIMIT [NUM_CLASSES] = '{
        17'd2, 17'd4, 17'd8, 17'd16, 17'd32, 17'd64, 17'd128, 17'd192,
        17'd256, 17'd512, 17'd1024, 17'd2048, 17'd4096, 17'd8192,
        17'd16384, 17'd32768, 17'd49152
    };
    localparam logic [SHIFT_W-1:0] LAD_LOG2K [NUM_CLASSES] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
        5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16
    };
    localparam logic LAD_QUARTER [NUM_CLASSES] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
    };

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_RAW   = 2'd1,
        REQ_GREY  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_RANGE = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

    typedef struct packed {
        t_req               kind;
        logic [COORD_W-1:0] x_lo;
        logic [COORD_W-1:0] x_hi;
        logic [COORD_W-1:0] y_lo;
        logic [COORD_W-1:0] y_hi;
        logic               empty;
        logic               in_map;
        logic [DEPTH_W-1:0] depth;
    } t_cmd;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_out;
        logic [GREY_W-1:0]  grey_out;
        logic [DEPTH_W-1:0] range_min;
        logic [DEPTH_W-1:0] range_max;
        logic               range_valid;
        logic [COUNT_W-1:0] entry_count;
        t_status            status;
    } t_res;

    typedef struct packed {
        logic               hit;
        logic               zero;
        logic               quarter;
        logic [SHIFT_W-1:0] shift;
    } t_cls;

    // first class whose limit lies above the span wins
    function automatic t_cls span_class(input logic [SPAN_W-1:0] span,
                                        input int depth_bits,
                                        input int grey_shift);
        t_cls c;
        int   classes;
        c = '0;
        classes = (grey_shift == 8) ? NUM_CLASSES : NARROW_CLASSES;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (i < classes && span < LAD_LIMIT[i]) begin
                c.hit     = 1'b1;
                c.quarter = LAD_QUARTER[i];
                if (int'(LAD_LOG2K[i]) <= depth_bits) begin
                    c.zero  = 1'b0;
                    c.shift = SHIFT_W'(depth_bits - int'(LAD_LOG2K[i]));
                end else begin
                    c.zero  = 1'b1;
                    c.shift = '0;
                end
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/dmgn_if.sv -----
interface dmgn_req_if import dmgn_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [DEPTH_W-1:0] depth_in;

    modport source (
        output valid, req_type, x_start, y_start, x_end, y_end, depth_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, x_start, y_start, x_end, y_end, depth_in,
        output ready
    );
endinterface

interface dmgn_res_if import dmgn_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DEPTH_W-1:0]  depth_out;
    logic [GREY_W-1:0]   grey_out;
    logic [DEPTH_W-1:0]  range_min;
    logic [DEPTH_W-1:0]  range_max;
    logic                range_valid;
    logic [COUNT_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, depth_out, grey_out, range_min, range_max, range_valid,
               entry_count, status,
        input  ready
    );
    modport sink (
        input  valid, depth_out, grey_out, range_min, range_max, range_valid,
               entry_count, status,
        output ready
    );
endinterface

// ----- hdl/dmgn_front.sv -----
module dmgn_front import dmgn_pkg::*; #(
    parameter int MAP_WIDTH  = DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = DEF_MAP_HEIGHT
) (
    dmgn_req_if.sink    i_req,
    input  logic        i_busy,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [COORD_W-1:0] x_hi;
    logic [COORD_W-1:0] y_hi;

    // clip the rectangle to the store edge
    assign x_hi = (int'(i_req.x_end) >= MAP_WIDTH)  ? COORD_W'(MAP_WIDTH - 1)  : i_req.x_end;
    assign y_hi = (int'(i_req.y_end) >= MAP_HEIGHT) ? COORD_W'(MAP_HEIGHT - 1) : i_req.y_end;

    assign i_req.ready = !i_full && !i_busy;
    assign o_push      = i_req.valid && i_req.ready;

    always_comb begin
        o_cmd.kind   = t_req'(i_req.req_type);
        o_cmd.x_lo   = i_req.x_start;
        o_cmd.x_hi   = x_hi;
        o_cmd.y_lo   = i_req.y_start;
        o_cmd.y_hi   = y_hi;
        o_cmd.empty  = (i_req.x_start > x_hi) || (i_req.y_start > y_hi);
        o_cmd.in_map = (int'(i_req.x_start) < MAP_WIDTH) && (int'(i_req.y_start) < MAP_HEIGHT);
        o_cmd.depth  = i_req.depth_in;
    end

endmodule

// ----- hdl/dmgn_fifo.sv -----
module dmgn_fifo import dmgn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (int'(r_wr) == QUEUE_DEPTH - 1) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (int'(r_rd) == QUEUE_DEPTH - 1) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hdl/dmgn_back.sv -----
module dmgn_back import dmgn_pkg::*; #(
    parameter int MAP_WIDTH  = DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = DEF_MAP_HEIGHT,
    parameter int DEPTH_BITS = DEF_DEPTH_BITS,
    parameter int GREY_SHIFT = DEF_GREY_SHIFT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [MARGIN_W-1:0] i_cfg_wdata,
    input  logic                i_q_valid,
    input  t_cmd                i_q_cmd,
    output logic                o_pop,
    output logic                o_busy,
    dmgn_res_if.source          o_res
);

    localparam int EFF_W     = (MAP_WIDTH  < 256) ? MAP_WIDTH  : 256;
    localparam int EFF_H     = (MAP_HEIGHT < 256) ? MAP_HEIGHT : 256;
    localparam int XB        = $clog2(EFF_W);
    localparam int YB        = $clog2(EFF_H);
    localparam int AB        = XB + YB;
    localparam int MEM_DEPTH = 2 ** AB;
    localparam int DB        = DEPTH_BITS;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_WRD   = 8'b0000_0100,
        S_WWR   = 8'b0000_1000,
        S_RRD   = 8'b0001_0000,
        S_RDAT  = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state              r_state,  n_state;
    t_cmd                r_cmd,    n_cmd;
    logic [COORD_W-1:0]  r_x,      n_x;
    logic [COORD_W-1:0]  r_y,      n_y;
    logic [AB-1:0]       r_clr,    n_clr;
    logic [DB-1:0]       r_min,    n_min;
    logic [DB-1:0]       r_max,    n_max;
    logic [DB-1:0]       r_span,   n_span;
    logic                r_sv,     n_sv;
    logic [COUNT_W-1:0]  r_cnt,    n_cnt;
    logic [MARGIN_W-1:0] r_margin, n_margin;
    logic [DB-1:0]       r_dout,   n_dout;
    t_status             r_status, n_status;
    logic [DB-1:0]       r_vinv,   n_vinv;
    logic [PROD_W-1:0]   r_prod,   n_prod;
    logic                r_ovalid, n_ovalid;
    t_res                r_res,    n_res;

    logic [DB-1:0]       r_mem [MEM_DEPTH];
    logic [DB-1:0]       r_rdata;
    logic                mem_we;
    logic [AB-1:0]       mem_waddr;
    logic [DB-1:0]       mem_wdata;
    logic [AB-1:0]       raddr;

    logic [DB-1:0]       d;
    logic [DB-1:0]       dval;
    t_cls                cls;
    logic [DB-1:0]       preval;
    logic [DB-1:0]       shl;
    logic [DB-1:0]       qtr;
    logic [DB-1:0]       nrm;
    logic [AVAIL_W-1:0]  avail;
    logic [DEPTH_W-1:0]  comp;
    logic [DEPTH_W-1:0]  comp_sh;
    logic [GREY_W-1:0]   grey;
    logic                out_free;

    assign raddr    = {r_y[YB-1:0], r_x[XB-1:0]};
    assign d        = r_cmd.depth[DB-1:0];
    assign o_busy   = (r_state == S_CLEAR);
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !r_ovalid || o_res.ready;

    // normalize against the span class, then invert
    assign dval   = r_cmd.in_map ? r_rdata : '0;
    assign cls    = span_class(SPAN_W'(r_span), DEPTH_BITS, GREY_SHIFT);
    assign preval = cls.hit ? dval - r_min : dval;
    assign shl    = cls.zero ? '0 : preval << cls.shift;
    assign qtr    = cls.quarter ? preval >> 2 : '0;
    assign nrm    = shl + qtr;

    // compress into the band between the margins
    assign avail   = AVAIL_W'(256) - {1'b0, r_margin, 1'b0};
    assign comp    = r_prod[COMP_LSB +: DEPTH_W];
    assign comp_sh = comp >> GREY_SHIFT;
    assign grey    = {1'b0, r_margin} + comp_sh[GREY_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_x      = r_x;
        n_y      = r_y;
        n_clr    = r_clr;
        n_min    = r_min;
        n_max    = r_max;
        n_span   = r_span;
        n_sv     = r_sv;
        n_cnt    = r_cnt;
        n_margin = i_cfg_we ? i_cfg_wdata : r_margin;
        n_dout   = r_dout;
        n_status = r_status;
        n_vinv   = r_vinv;
        n_prod   = r_prod;
        n_ovalid = r_ovalid && !o_res.ready;
        n_res    = r_res;
        mem_we    = 1'b0;
        mem_waddr = raddr;
        mem_wdata = d;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_cmd    = i_q_cmd;
                    n_x      = i_q_cmd.x_lo;
                    n_y      = i_q_cmd.y_lo;
                    n_dout   = '0;
                    n_status = ST_OK;
                    case (i_q_cmd.kind)
                        REQ_WRITE: n_state = i_q_cmd.empty ? S_OUT : S_WRD;
                        REQ_RAW:   n_state = S_RRD;
                        REQ_GREY:  n_state = S_RRD;
                        default:   n_state = S_OUT;
                    endcase
                end
            end
            S_WRD: begin
                n_state = S_WWR;
            end
            S_WWR: begin
                mem_we = 1'b1;
                if (!r_sv) begin
                    n_min  = d;
                    n_max  = d;
                    n_span = '0;
                    n_sv   = 1'b1;
                end else if (d < r_min) begin
                    n_min  = d;
                    n_span = r_max - d;
                end else if (d > r_max) begin
                    n_max  = d;
                    n_span = d - r_min;
                end
                if (r_rdata == '0 && r_cnt != COUNT_MAX) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_y == r_cmd.y_hi) begin
                    n_y = r_cmd.y_lo;
                    if (r_x == r_cmd.x_hi) begin
                        n_state = S_OUT;
                    end else begin
                        n_x     = r_x + 1'b1;
                        n_state = S_WRD;
                    end
                end else begin
                    n_y     = r_y + 1'b1;
                    n_state = S_WRD;
                end
            end
            S_RRD: begin
                n_state = S_RDAT;
            end
            S_RDAT: begin
                n_dout = dval;
                n_vinv = ~nrm;
                if (r_cmd.kind == REQ_GREY) begin
                    if (!r_sv) begin
                        n_status = ST_NO_RANGE;
                    end else if (dval < r_min || dval > r_max) begin
                        n_status = ST_OUTSIDE;
                    end
                    n_state = S_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_vinv) * PROD_W'(avail);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid          = 1'b1;
                    n_res.depth_out   = DEPTH_W'(r_dout);
                    n_res.grey_out    = (r_cmd.kind == REQ_GREY && r_status == ST_OK) ?
                                        grey : '0;
                    n_res.range_min   = DEPTH_W'(r_min);
                    n_res.range_max   = DEPTH_W'(r_max);
                    n_res.range_valid = r_sv;
                    n_res.entry_count = r_cnt;
                    n_res.status      = r_status;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_span   <= '0;
            r_sv     <= 1'b0;
            r_cnt    <= '0;
            r_margin <= MARGIN_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_min    <= n_min;
            r_max    <= n_max;
            r_span   <= n_span;
            r_sv     <= n_sv;
            r_cnt    <= n_cnt;
            r_margin <= n_margin;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_x      <= n_x;
        r_y      <= n_y;
        r_dout   <= n_dout;
        r_status <= n_status;
        r_vinv   <= n_vinv;
        r_prod   <= n_prod;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.depth_out   = r_res.depth_out;
    assign o_res.grey_out    = r_res.grey_out;
    assign o_res.range_min   = r_res.range_min;
    assign o_res.range_max   = r_res.range_max;
    assign o_res.range_valid = r_res.range_valid;
    assign o_res.entry_count = r_res.entry_count;
    assign o_res.status      = r_res.status;

`ifndef SYNTHESIS
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> (r_min <= r_max))
        else $error("range minimum above maximum");
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> (r_span == DB'(r_max - r_min)))
        else $error("span out of step with range");
    a_cnt_no_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sv |-> (r_cnt == '0))
        else $error("count moved before any write");
    a_cnt_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) |-> $past(r_state == S_WWR))
        else $error("count moved outside a cell write");
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");
`endif

endmodule

// ----- hdl/depth_map_grey_normalizer_top.sv -----
// channel   dir  transfer when         payload
// i_req     in   valid && ready        req_type, x_start, y_start, x_end, y_end, depth_in
// o_res     out  valid && ready        depth_out, grey_out, range_min, range_max,
//                                      range_valid, entry_count, status
// i_cfg     in   i_cfg_we high         grey_margin (7 bits)
//
// After the queue: write S_WRD, S_WWR per cell (a store read and a write per cell); raw
// read S_RRD, S_RDAT; grey read adds S_MUL; empty write, unknown: none; each ends in S_OUT.
// Reset: store swept to zero, one entry a cycle, all 2**(clog2(W)+clog2(H)) entries
// (65536 at 256x256, W and H capped at 256); i_req.ready low meanwhile.
// A two-entry queue parts intake from execution; the result register holds under stall.
module depth_map_grey_normalizer_top import dmgn_pkg::*; #(
    parameter int MAP_WIDTH  = DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = DEF_MAP_HEIGHT,
    parameter int DEPTH_BITS = DEF_DEPTH_BITS,
    parameter int GREY_SHIFT = DEF_GREY_SHIFT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [MARGIN_W-1:0] i_cfg_wdata,
    dmgn_req_if.sink            i_req,
    dmgn_res_if.source          o_res
);

    logic busy;
    logic full;
    logic push;
    logic q_valid;
    logic pop;
    t_cmd push_cmd;
    t_cmd q_cmd;

    dmgn_front #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_front (
        .i_req  (i_req),
        .i_busy (busy),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    dmgn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (pop)
    );

    dmgn_back #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS),
        .GREY_SHIFT (GREY_SHIFT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .o_busy      (busy),
        .o_res       (o_res)
    );

endmodule

// ----- dv/depth_map_grey_normalizer_top_tb.sv -----
module depth_map_grey_normalizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmgn_pkg::*;

    localparam int MAP_W = DEF_MAP_WIDTH;
    localparam int MAP_H = DEF_MAP_HEIGHT;
    localparam int unsigned DEPTH_MASK = (1 << DEF_DEPTH_BITS) - 1;
    localparam logic [DEPTH_W-1:0] MID_DEPTH = 16'h8000;
    localparam int HOLD_CYCLES = 300;

    localparam int unsigned SPAN_LIMIT [17] = '{
        2, 4, 8, 16, 32, 64, 128, 192, 256, 512, 1024, 2048, 4096, 8192,
        16384, 32768, 49152
    };
    localparam int unsigned SPAN_LOG2K [17] = '{
        1, 2, 3, 4, 5, 6, 7, 8, 8, 9, 10, 11, 12, 13, 14, 15, 16
    };
    localparam bit SPAN_QUARTER [17] = '{
        0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1
    };
    // depth spread per phase, so the running span climbs through every class
    localparam int unsigned LADDER_SPREAD [19] = '{
        0, 1, 3, 7, 15, 31, 63, 127, 160, 255, 511, 1023, 2047, 4095, 8191,
        16383, 32767, 45000, 65535
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [MARGIN_W-1:0] i_cfg_wdata = '0;
    logic                rx_ready = 1'b0;

    dmgn_req_if req_if ();
    dmgn_res_if res_if ();

    assign res_if.ready = rx_ready;

    depth_map_grey_normalizer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // mirror of the block state
    logic [DEPTH_W-1:0]  depth_mem [MAP_W*MAP_H];
    logic [DEPTH_W-1:0]  depth_lo = '0;
    logic [DEPTH_W-1:0]  depth_hi = '0;
    int unsigned         depth_span = 0;
    bit                  range_seen = 1'b0;
    logic [COUNT_W-1:0]  zero_hits = '0;
    logic [MARGIN_W-1:0] grey_margin_now = MARGIN_RESET;

    t_res replies_due [$];
    int   errors = 0;

    // receiver pattern
    bit          choppy = 1'b0;
    int unsigned hold_asks = 0;
    int unsigned hold_acks = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #25_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [GREY_W-1:0] grey_level(logic [DEPTH_W-1:0] d);
        int unsigned    classes;
        int unsigned    base;
        int unsigned    factor;
        int unsigned    qtr;
        bit             found;
        longint unsigned preval;
        longint unsigned n;
        longint unsigned v;
        longint unsigned avail;
        longint unsigned scale;
        longint unsigned comp;
        classes = (DEF_GREY_SHIFT == 8) ? 17 : 8;
        base = 0;
        factor = 1;
        qtr = 0;
        found = 1'b0;
        for (int i = 0; i < classes; i++) begin
            if (!found && depth_span < SPAN_LIMIT[i]) begin
                found = 1'b1;
                base = depth_lo;
                factor = (SPAN_LOG2K[i] <= DEF_DEPTH_BITS) ?
                         (1 << (DEF_DEPTH_BITS - SPAN_LOG2K[i])) : 0;
                qtr = SPAN_QUARTER[i];
            end
        end
        preval = (d - base) & DEPTH_MASK;
        n = (preval * factor + (preval / 4) * qtr) & DEPTH_MASK;
        v = (DEPTH_MASK - n) & DEPTH_MASK;
        avail = 256 - 2 * grey_margin_now;
        scale = (avail << 16) / 256;
        comp = ((v * scale) >> 16) & 16'hFFFF;
        return GREY_W'((grey_margin_now + (comp >> DEF_GREY_SHIFT)) & 8'hFF);
    endfunction

    function automatic t_res serve_request(t_req k, logic [7:0] xs, logic [7:0] ys,
                                           logic [7:0] xe, logic [7:0] ye,
                                           logic [DEPTH_W-1:0] din);
        t_res               r;
        logic [DEPTH_W-1:0] d;
        logic [DEPTH_W-1:0] stored;
        r = '0;
        r.status = ST_OK;
        d = DEPTH_W'(din & DEPTH_MASK);
        stored = '0;
        if ((k == REQ_RAW || k == REQ_GREY) && xs < MAP_W && ys < MAP_H)
            stored = depth_mem[ys*MAP_W + xs];
        case (k)
            REQ_WRITE: begin
                for (int x = xs; x <= xe && x < MAP_W; x++) begin
                    for (int y = ys; y <= ye && y < MAP_H; y++) begin
                        if (depth_mem[y*MAP_W + x] == '0 && zero_hits != COUNT_MAX)
                            zero_hits++;
                        depth_mem[y*MAP_W + x] = d;
                        if (!range_seen) begin
                            depth_lo = d;
                            depth_hi = d;
                            depth_span = 0;
                            range_seen = 1'b1;
                        end else begin
                            if (d < depth_lo) begin
                                depth_lo = d;
                                depth_span = depth_hi - depth_lo;
                            end
                            if (d > depth_hi) begin
                                depth_hi = d;
                                depth_span = depth_hi - depth_lo;
                            end
                        end
                    end
                end
            end
            REQ_GREY: begin
                if (!range_seen)
                    r.status = ST_NO_RANGE;
                else if (stored < depth_lo || stored > depth_hi)
                    r.status = ST_OUTSIDE;
                else
                    r.grey_out = grey_level(stored);
            end
            default: ;
        endcase
        r.depth_out = stored;
        r.range_min = depth_lo;
        r.range_max = depth_hi;
        r.range_valid = range_seen;
        r.entry_count = zero_hits;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [16:0] got, logic [16:0] want);
        if (errors < 100)
            $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic check_field(string what, logic [16:0] got, logic [16:0] want);
        if (got !== want)
            flag_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready) begin
            if (replies_due.size() == 0) begin
                flag_mismatch("reply with none due, depth_out", 17'(res_if.depth_out), '0);
            end else begin
                want = replies_due.pop_front();
                check_field("depth_out", 17'(res_if.depth_out), 17'(want.depth_out));
                check_field("grey_out", 17'(res_if.grey_out), 17'(want.grey_out));
                check_field("range_min", 17'(res_if.range_min), 17'(want.range_min));
                check_field("range_max", 17'(res_if.range_max), 17'(want.range_max));
                check_field("range_valid", 17'(res_if.range_valid),
                            17'(want.range_valid));
                check_field("entry_count", res_if.entry_count, want.entry_count);
                check_field("status", 17'(res_if.status), 17'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_asks != hold_acks) begin
            hold_acks <= hold_asks;
            hold_left <= HOLD_CYCLES;
            rx_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rx_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rx_ready <= 1'b0;
        end else if (choppy && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 5);
            rx_ready <= 1'b0;
        end else begin
            rx_ready <= 1'b1;
        end
    end

    task automatic send_req(t_req k, logic [7:0] xs, logic [7:0] ys, logic [7:0] xe,
                            logic [7:0] ye, logic [DEPTH_W-1:0] d);
        req_if.valid <= 1'b1;
        req_if.req_type <= k;
        req_if.x_start <= xs;
        req_if.y_start <= ys;
        req_if.x_end <= xe;
        req_if.y_end <= ye;
        req_if.depth_in <= d;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1)
            @(posedge i_clk);
        replies_due.push_back(serve_request(k, xs, ys, xe, ye, d));
    endtask

    task automatic drain_replies();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_margin(logic [MARGIN_W-1:0] m);
        drain_replies();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        grey_margin_now = m;
    endtask

    task automatic send_random(logic [DEPTH_W-1:0] lo, int unsigned spread);
        t_req               k;
        logic [7:0]         xs;
        logic [7:0]         ys;
        logic [7:0]         xe;
        logic [7:0]         ye;
        logic [DEPTH_W-1:0] d;
        int unsigned        roll;
        int unsigned        w;
        int unsigned        h;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            k = REQ_WRITE;
        else if (roll < 65)
            k = REQ_RAW;
        else if (roll < 95)
            k = REQ_GREY;
        else
            k = REQ_NONE;
        if ($urandom_range(0, 99) < 85) begin
            xs = 8'($urandom_range(0, 15));
            ys = 8'($urandom_range(0, 15));
        end else begin
            xs = 8'($urandom_range(0, 255));
            ys = 8'($urandom_range(0, 255));
        end
        xe = 8'($urandom_range(0, 255));
        ye = 8'($urandom_range(0, 255));
        d = 16'($urandom_range(0, 65535));
        if (k == REQ_WRITE) begin
            d = 16'(lo + $urandom_range(0, spread));
            roll = $urandom_range(0, 99);
            if (roll < 5 && xs != 0) begin
                xe = 8'($urandom_range(0, xs - 1));
            end else begin
                w = (roll < 88) ? $urandom_range(1, 4) :
                    (roll < 97) ? $urandom_range(1, 16) : $urandom_range(1, 40);
                h = (roll < 88) ? $urandom_range(1, 4) :
                    (roll < 97) ? $urandom_range(1, 16) : $urandom_range(1, 40);
                xe = 8'(xs + w - 1);
                ye = 8'(ys + h - 1);
            end
        end
        send_req(k, xs, ys, xe, ye, d);
    endtask

    task automatic test_before_range();
        send_req(REQ_GREY, 0, 0, 0, 0, 0);
        send_req(REQ_RAW, 255, 255, 255, 255, 16'hFFFF);
        send_req(REQ_NONE, 255, 255, 255, 255, 16'hFFFF);
        send_req(REQ_WRITE, 5, 0, 4, 0, MID_DEPTH);
        send_req(REQ_GREY, 255, 0, 0, 255, 0);
    endtask

    task automatic test_first_depth();
        send_req(REQ_WRITE, 10, 10, 10, 10, MID_DEPTH);
        send_req(REQ_RAW, 10, 10, 0, 0, 0);
        send_req(REQ_GREY, 10, 10, 0, 0, 0);
        send_req(REQ_GREY, 11, 10, 0, 0, 0);
        send_req(REQ_WRITE, 0, 0, 3, 3, MID_DEPTH);
        send_req(REQ_WRITE, 10, 10, 10, 10, MID_DEPTH);
        send_req(REQ_WRITE, 0, 9, 0, 8, MID_DEPTH);
    endtask

    task automatic test_margin_extremes();
        set_margin(0);
        send_req(REQ_GREY, 10, 10, 0, 0, 0);
        send_req(REQ_GREY, 2, 3, 0, 0, 0);
        set_margin(127);
        send_req(REQ_GREY, 10, 10, 0, 0, 0);
        set_margin(MARGIN_RESET);
        send_req(REQ_GREY, 0, 0, 0, 0, 0);
    endtask

    task automatic test_span_ladder();
        logic [DEPTH_W-1:0] lo;
        int unsigned        burst;
        int unsigned        gap;
        bit                 calm;
        for (int s = 0; s < 19; s++) begin
            lo = (LADDER_SPREAD[s] >= 65535) ? '0 : 16'(MID_DEPTH - LADDER_SPREAD[s] / 2);
            if (s == 0)
                set_margin(0);
            else if (s == 17)
                set_margin(127);
            else if (s % 4 == 1)
                set_margin(MARGIN_RESET);
            else
                set_margin(MARGIN_W'($urandom_range(0, 127)));
            calm = (s % 3 == 2);
            choppy <= !calm;
            burst = 0;
            repeat (95) begin
                if (!calm && burst == 0) begin
                    burst = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap != 0) begin
                        req_if.valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                send_random(lo, LADDER_SPREAD[s]);
                if (burst != 0)
                    burst--;
            end
        end
    endtask

    task automatic test_backpressure();
        drain_replies();
        choppy <= 1'b0;
        hold_asks <= hold_asks + 1;
        repeat (30) send_random('0, 65535);
        drain_replies();
        choppy <= 1'b1;
        repeat (10) send_random('0, 65535);
    endtask

    task automatic test_wide_span();
        set_margin(127);
        send_req(REQ_WRITE, 255, 255, 255, 255, 16'hFFFF);
        send_req(REQ_WRITE, 254, 255, 254, 255, 16'h0000);
        send_req(REQ_GREY, 255, 255, 0, 0, 0);
        send_req(REQ_GREY, 254, 255, 0, 0, 0);
        send_req(REQ_RAW, 255, 255, 0, 0, 0);
        send_req(REQ_WRITE, 0, 200, 255, 200, 16'($urandom_range(0, 65535)));
        send_req(REQ_WRITE, 128, 0, 128, 255, 16'h00FF);
        set_margin(0);
        send_req(REQ_GREY, 255, 255, 0, 0, 0);
        send_req(REQ_GREY, 0, 200, 0, 0, 0);
        send_req(REQ_GREY, 128, 77, 0, 0, 0);
        send_req(REQ_GREY, 250, 3, 0, 0, 0);
        send_req(REQ_RAW, 255, 0, 0, 0, 0);
        send_req(REQ_NONE, 0, 0, 0, 0, 0);
    endtask

    // two full sweeps of zero push the counter up to its ceiling
    task automatic test_count_saturation();
        set_margin(MARGIN_RESET);
        send_req(REQ_WRITE, 0, 0, 255, 255, 16'h0000);
        send_req(REQ_WRITE, 0, 0, 255, 255, 16'h0000);
        send_req(REQ_WRITE, 3, 3, 3, 3, 16'h0000);
        send_req(REQ_RAW, 3, 3, 0, 0, 0);
        send_req(REQ_GREY, 3, 3, 0, 0, 0);
        send_req(REQ_WRITE, 7, 7, 7, 7, 16'h0005);
        send_req(REQ_GREY, 7, 7, 0, 0, 0);
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.req_type = REQ_NONE;
        req_if.x_start = '0;
        req_if.y_start = '0;
        req_if.x_end = '0;
        req_if.y_end = '0;
        req_if.depth_in = '0;
        foreach (depth_mem[i])
            depth_mem[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_before_range();
        test_first_depth();
        test_margin_extremes();
        test_span_ladder();
        test_backpressure();
        test_wide_span();
        test_count_saturation();

        drain_replies();
        repeat (16) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/dmgn_pkg.sv
hdl/dmgn_if.sv
hdl/dmgn_front.sv
hdl/dmgn_fifo.sv
hdl/dmgn_back.sv
hdl/depth_map_grey_normalizer_top.sv
dv/depth_map_grey_normalizer_top_tb.sv
